// ===== rtl/core/chm_pkg.sv =====
`default_nettype none
package chm_pkg;

   // Geometry (BUCKET_COUNT is a power of two: the bucket is the key's low bits)
   localparam int BUCKET_COUNT = 64;
   localparam int NODE_COUNT   = 256;
   localparam int BKT_W        = $clog2(BUCKET_COUNT);
   localparam int ADDR_W       = $clog2(NODE_COUNT);
   localparam int IDX_W        = $clog2(NODE_COUNT + 1);
   localparam int KEY_W        = 16;
   localparam int VAL_W        = 32;
   localparam int ACT_W        = 2;
   localparam int STAT_W       = 2;

   typedef logic [IDX_W-1:0] idx_type;

   // Null node index terminates every chain
   localparam idx_type NIL = IDX_W'(NODE_COUNT);

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_ABSENT = 2'd2
   } status_type;

   // Bucket head memory command
   typedef struct packed {
      logic [BKT_W-1:0] raddr;
      logic             we;
      logic [BKT_W-1:0] waddr;
      idx_type          wdata;
   } bkt_cmd_type;

   // Node pool memory command
   typedef struct packed {
      logic [ADDR_W-1:0] raddr;
      logic              kv_we;
      logic              next_we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      idx_type           next;
   } node_cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      idx_type          next;
   } node_rd_type;

endpackage
`default_nettype wire

// ===== rtl/core/chm_if.sv =====
`default_nettype none
// Request channel
interface chm_req_if;
   logic                        valid;
   logic                        ready;
   logic [chm_pkg::ACT_W-1:0]   action;
   logic [chm_pkg::KEY_W-1:0]   key;
   logic [chm_pkg::VAL_W-1:0]   value;
   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

// Response channel
interface chm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [chm_pkg::VAL_W-1:0]   lookup_value;
   logic [chm_pkg::STAT_W-1:0]  status;
   modport source (output valid, found, lookup_value, status, input ready);
   modport sink   (input valid, found, lookup_value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/chm_bucket_mem.sv =====
`default_nettype none
// Bucket head memory; unwritten buckets read as the null index
module chm_bucket_mem (
   input  wire                   clock,
   input  wire                   reset,
   input  chm_pkg::bkt_cmd_type  cmd,
   output chm_pkg::idx_type      rdata
);
   chm_pkg::idx_type                  head_mem [chm_pkg::BUCKET_COUNT];
   logic [chm_pkg::BUCKET_COUNT-1:0]  valid_ff;
   chm_pkg::idx_type                  rd_head_ff;
   logic                              rd_valid_ff;

   // Per-bucket valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.we) begin
         valid_ff[cmd.waddr] <= 1'b1;
      end
   end

   // Storage with registered read
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         head_mem[cmd.waddr] <= cmd.wdata;
      end
      rd_head_ff  <= head_mem[cmd.raddr];
      rd_valid_ff <= valid_ff[cmd.raddr];
   end

   assign rdata = rd_valid_ff ? rd_head_ff : chm_pkg::NIL;
endmodule
`default_nettype wire

// ===== rtl/core/chm_node_mem.sv =====
`default_nettype none
// Node pool: key/value and next-link memories, one read address
module chm_node_mem (
   input  wire                   clock,
   input  chm_pkg::node_cmd_type cmd,
   output chm_pkg::node_rd_type  rdata
);
   logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] kv_mem   [chm_pkg::NODE_COUNT];
   chm_pkg::idx_type                         next_mem [chm_pkg::NODE_COUNT];
   logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] rd_kv_ff;
   chm_pkg::idx_type                         rd_next_ff;

   always_ff @(posedge clock) begin
      if (cmd.kv_we) begin
         kv_mem[cmd.waddr] <= {cmd.key, cmd.value};
      end
      rd_kv_ff <= kv_mem[cmd.raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.next_we) begin
         next_mem[cmd.waddr] <= cmd.next;
      end
      rd_next_ff <= next_mem[cmd.raddr];
   end

   assign rdata.key   = rd_kv_ff[chm_pkg::KEY_W+chm_pkg::VAL_W-1:chm_pkg::VAL_W];
   assign rdata.value = rd_kv_ff[chm_pkg::VAL_W-1:0];
   assign rdata.next  = rd_next_ff;
endmodule
`default_nettype wire

// ===== rtl/core/chained_hash_map_core.sv =====
`default_nettype none
// Channel | Dir | Fields
// req     | in  | action[1:0], key[15:0], value[31:0]
// rsp     | out | found, lookup_value[31:0], status[1:0]
//
// One transaction at a time. Insert: S_INS, then S_DONE. Lookup/remove:
// S_WALK_HEAD, S_WALK_CHK per chain node visited (plus S_REM_LINK to relink
// a non-head node), then S_DONE. Clear: S_CLR_HEAD per bucket plus S_CLR_WALK
// per chained node. Reset is synchronous; the bucket valid bits clear at once
// and never-used pool nodes are tracked by a fill mark, so no clearing pass.
// A result held in rsp while its sink stalls blocks only the next result.
module chained_hash_map_core (
   input wire         clock,
   input wire         reset,
   chm_req_if.sink    req,
   chm_rsp_if.source  rsp
);
   typedef enum logic [2:0] {
      S_IDLE, S_INS, S_WALK_HEAD, S_WALK_CHK, S_REM_LINK, S_CLR_HEAD, S_CLR_WALK, S_DONE
   } state_type;

   localparam logic [chm_pkg::BKT_W-1:0] BKT_LAST = chm_pkg::BKT_W'(chm_pkg::BUCKET_COUNT - 1);

   state_type                    state_ff, state_in;
   chm_pkg::action_type          act_ff, act_in;
   logic [chm_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [chm_pkg::VAL_W-1:0]    val_ff, val_in;
   chm_pkg::idx_type             free_head_ff, free_head_in;
   chm_pkg::idx_type             fresh_ff, fresh_in;
   chm_pkg::idx_type             cur_ff, cur_in;
   chm_pkg::idx_type             prev_ff, prev_in;
   chm_pkg::idx_type             head_ff, head_in;
   chm_pkg::idx_type             link_ff, link_in;
   logic [chm_pkg::BKT_W-1:0]    bi_ff, bi_in;
   logic                         found_ff, found_in;
   logic [chm_pkg::VAL_W-1:0]    lv_ff, lv_in;
   chm_pkg::status_type          status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [chm_pkg::VAL_W-1:0]    rsp_lv_ff, rsp_lv_in;
   chm_pkg::status_type          rsp_status_ff, rsp_status_in;

   chm_pkg::bkt_cmd_type         bkt_cmd;
   chm_pkg::idx_type             bkt_rdata;
   chm_pkg::node_cmd_type        node_cmd;
   chm_pkg::node_rd_type         node_rd;
   logic                         req_take;
   logic [chm_pkg::BKT_W-1:0]    key_bkt;

   chm_bucket_mem u_bkt (.clock(clock), .reset(reset), .cmd(bkt_cmd), .rdata(bkt_rdata));
   chm_node_mem   u_node (.clock(clock), .cmd(node_cmd), .rdata(node_rd));

   assign req.ready        = (state_ff == S_IDLE);
   assign req_take         = req.valid && req.ready;
   assign key_bkt          = key_ff[chm_pkg::BKT_W-1:0];
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.lookup_value = rsp_lv_ff;
   assign rsp.status       = rsp_status_ff;

   // Sequencer: next state, memory commands, result
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      link_in       = link_ff;
      bi_in         = bi_ff;
      found_in      = found_ff;
      lv_in         = lv_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_lv_in     = rsp_lv_ff;
      rsp_status_in = rsp_status_ff;
      bkt_cmd       = '0;
      node_cmd      = '0;
      node_cmd.key  = key_ff;
      node_cmd.value = val_ff;

      case (state_ff)
         S_IDLE: begin
            bkt_cmd.raddr  = req.key[chm_pkg::BKT_W-1:0];
            node_cmd.raddr = free_head_ff[chm_pkg::ADDR_W-1:0];
            if (req_take) begin
               act_in    = chm_pkg::action_type'(req.action);
               key_in    = req.key;
               val_in    = req.value;
               found_in  = 1'b0;
               lv_in     = '0;
               status_in = chm_pkg::STAT_OK;
               bi_in     = '0;
               case (chm_pkg::action_type'(req.action))
                  chm_pkg::ACT_INSERT: state_in = S_INS;
                  chm_pkg::ACT_CLEAR: begin
                     bkt_cmd.raddr = '0;
                     state_in      = S_CLR_HEAD;
                  end
                  default: state_in = S_WALK_HEAD;
               endcase
            end
         end

         // Pop free node, push it at the chain head, or report full
         S_INS: begin
            state_in = S_DONE;
            if (free_head_ff == chm_pkg::NIL) begin
               status_in = chm_pkg::STAT_FULL;
            end else begin
               node_cmd.kv_we   = 1'b1;
               node_cmd.next_we = 1'b1;
               node_cmd.waddr   = free_head_ff[chm_pkg::ADDR_W-1:0];
               node_cmd.next    = bkt_rdata;
               bkt_cmd.we       = 1'b1;
               bkt_cmd.waddr    = key_bkt;
               bkt_cmd.wdata    = free_head_ff;
               if (free_head_ff == fresh_ff) begin
                  // never-used node: its link is the following node
                  free_head_in = free_head_ff + 1'b1;
                  fresh_in     = fresh_ff + 1'b1;
               end else begin
                  free_head_in = node_rd.next;
               end
            end
         end

         S_WALK_HEAD: begin
            cur_in  = bkt_rdata;
            prev_in = chm_pkg::NIL;
            node_cmd.raddr = bkt_rdata[chm_pkg::ADDR_W-1:0];
            if (bkt_rdata == chm_pkg::NIL) begin
               status_in = chm_pkg::STAT_ABSENT;
               state_in  = S_DONE;
            end else begin
               state_in = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            node_cmd.raddr = node_rd.next[chm_pkg::ADDR_W-1:0];
            if (node_rd.key == key_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
               if (act_ff == chm_pkg::ACT_LOOKUP) begin
                  lv_in = node_rd.value;
               end else begin
                  // unlink and push onto free list
                  node_cmd.next_we = 1'b1;
                  node_cmd.waddr   = cur_ff[chm_pkg::ADDR_W-1:0];
                  node_cmd.next    = free_head_ff;
                  free_head_in     = cur_ff;
                  link_in          = node_rd.next;
                  if (prev_ff == chm_pkg::NIL) begin
                     bkt_cmd.we    = 1'b1;
                     bkt_cmd.waddr = key_bkt;
                     bkt_cmd.wdata = node_rd.next;
                  end else begin
                     state_in = S_REM_LINK;
                  end
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = node_rd.next;
               if (node_rd.next == chm_pkg::NIL) begin
                  status_in = chm_pkg::STAT_ABSENT;
                  state_in  = S_DONE;
               end
            end
         end

         S_REM_LINK: begin
            node_cmd.next_we = 1'b1;
            node_cmd.waddr   = prev_ff[chm_pkg::ADDR_W-1:0];
            node_cmd.next    = link_ff;
            state_in         = S_DONE;
         end

         // Clear: scan buckets, walk each chain to its tail
         S_CLR_HEAD: begin
            head_in = bkt_rdata;
            cur_in  = bkt_rdata;
            if (bkt_rdata == chm_pkg::NIL) begin
               if (bi_ff == BKT_LAST) begin
                  state_in = S_DONE;
               end else begin
                  bi_in         = bi_ff + 1'b1;
                  bkt_cmd.raddr = bi_ff + 1'b1;
               end
            end else begin
               node_cmd.raddr = bkt_rdata[chm_pkg::ADDR_W-1:0];
               state_in       = S_CLR_WALK;
            end
         end

         S_CLR_WALK: begin
            if (node_rd.next != chm_pkg::NIL) begin
               cur_in         = node_rd.next;
               node_cmd.raddr = node_rd.next[chm_pkg::ADDR_W-1:0];
            end else begin
               // splice chain in front of the free list, empty the bucket
               node_cmd.next_we = 1'b1;
               node_cmd.waddr   = cur_ff[chm_pkg::ADDR_W-1:0];
               node_cmd.next    = free_head_ff;
               free_head_in     = head_ff;
               bkt_cmd.we       = 1'b1;
               bkt_cmd.waddr    = bi_ff;
               bkt_cmd.wdata    = chm_pkg::NIL;
               if (bi_ff == BKT_LAST) begin
                  state_in = S_DONE;
               end else begin
                  bi_in         = bi_ff + 1'b1;
                  bkt_cmd.raddr = bi_ff + 1'b1;
                  state_in      = S_CLR_HEAD;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_lv_in     = lv_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      head_ff       <= head_in;
      link_ff       <= link_in;
      bi_ff         <= bi_in;
      found_ff      <= found_in;
      lv_ff         <= lv_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_lv_ff     <= rsp_lv_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/chm_checker.sv =====
`default_nettype none
module chm_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire                        rsp_found,
   input wire [chm_pkg::VAL_W-1:0]   rsp_lookup_value,
   input wire [chm_pkg::STAT_W-1:0]  rsp_status
);
   // Response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found))
      else $error("response dropped or changed under stall");

   // One transaction in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A match always reports ok
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == chm_pkg::STAT_OK)
      else $error("found with error status");

   // A value is returned only with a match
   a_value_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_lookup_value != '0) |-> rsp_found)
      else $error("value without match");
endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_found(rsp.found),
   .rsp_lookup_value(rsp.lookup_value),
   .rsp_status(rsp.status)
);
`default_nettype wire
